### hw/rtl/pixel_upscale_2x_average_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x pixel upscaler
// Shared clocking and reporting form for the checker's assertions.
// ----------------------------------------------------------------------------
`ifndef PIXEL_UPSCALE_2X_AVERAGE_CORE_ASSERT_SVH
`define PIXEL_UPSCALE_2X_AVERAGE_CORE_ASSERT_SVH

// Check on every rising clock edge outside reset.
`define PXU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define PXU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/pxu_pkg.sv
// ----------------------------------------------------------------------------
// pxu_pkg
// Widths, register indexes, pixel type and the per-channel mean.
// ----------------------------------------------------------------------------
package pxu_pkg;

   localparam int PIX_W        = 8;
   localparam int OUT_X_W      = 12;
   localparam int OUT_Y_W      = 13;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam int RESET_WIDTH        = 640;
   localparam int RESET_HEIGHT       = 480;
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   typedef logic [PIX_W-1:0] chan_type;

   typedef struct packed {
      chan_type c2;
      chan_type c1;
      chan_type c0;
   } pixel_type;

   // Truncated mean, channel by channel.
   function automatic pixel_type mean_px(pixel_type a, pixel_type b);
      logic [PIX_W:0] s0;
      logic [PIX_W:0] s1;
      logic [PIX_W:0] s2;
      pixel_type      r;
      s0   = {1'b0, a.c0} + {1'b0, b.c0};
      s1   = {1'b0, a.c1} + {1'b0, b.c1};
      s2   = {1'b0, a.c2} + {1'b0, b.c2};
      r.c0 = s0[PIX_W:1];
      r.c1 = s1[PIX_W:1];
      r.c2 = s2[PIX_W:1];
      return r;
   endfunction

endpackage

### hw/rtl/pxu_req_if.sv
// ----------------------------------------------------------------------------
// pxu_req_if
// Input pixel channel: valid/ready with the three color bytes.
// ----------------------------------------------------------------------------
interface pxu_req_if;
   logic               valid;
   logic               ready;
   pxu_pkg::chan_type  chan_0;
   pxu_pkg::chan_type  chan_1;
   pxu_pkg::chan_type  chan_2;

   modport source (output valid, output chan_0, output chan_1, output chan_2, input ready);
   modport sink   (input valid, input chan_0, input chan_1, input chan_2, output ready);
endinterface

### hw/rtl/pxu_rsp_if.sv
// ----------------------------------------------------------------------------
// pxu_rsp_if
// Output pixel channel: valid/ready with coordinates, color and markers.
// ----------------------------------------------------------------------------
interface pxu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pxu_pkg::OUT_X_W-1:0]   out_x;
   logic [pxu_pkg::OUT_Y_W-1:0]   out_y;
   pxu_pkg::chan_type             res_0;
   pxu_pkg::chan_type             res_1;
   pxu_pkg::chan_type             res_2;
   logic                          last_of_item;
   logic                          frame_done;

   modport source (output valid, output out_x, output out_y, output res_0, output res_1,
                   output res_2, output last_of_item, output frame_done, input ready);
   modport sink   (input valid, input out_x, input out_y, input res_0, input res_1,
                   input res_2, input last_of_item, input frame_done, output ready);
endinterface

### hw/rtl/pxu_ram.sv
// ----------------------------------------------------------------------------
// pxu_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pxu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pixel_upscale_2x_average_core.sv
// Path: an input pixel goes through stage A, stage B and the result register to rsp.
// Throughput: one result beat per cycle while rsp keeps up. An input pixel makes
// 1 to 9 beats, 4 on average over a frame; stage A takes a pixel while B emits.
// The single result register and the beat sequencer of the emit stage set this rate.
// Reset: synchronous, active high; clears counters and valids, sizes to 640 x 480.
// The line buffer is not cleared; each entry is written one row before it is read.
// ----------------------------------------------------------------------------
// pixel_upscale_2x_average_core
// Doubles a raster image in both directions, filling odd rows and columns with the
// truncated neighbor mean (a copy in the last ones) and tags each output's position.
// ----------------------------------------------------------------------------
module pixel_upscale_2x_average_core #(
   parameter int MAX_WIDTH  = pxu_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = pxu_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   pxu_req_if.sink                          req_chan,
   pxu_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [pxu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pxu_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // Clamp a size register to 1..MAX and return the index of the last column/row.
   function automatic logic [CW-1:0] last_col_of(logic [pxu_pkg::WIDTH_REG_W-1:0] w);
      int v;
      v = int'(w);
      if (v == 0) v = 1;
      if (v > MAX_WIDTH) v = MAX_WIDTH;
      return CW'(v - 1);
   endfunction

   function automatic logic [RW-1:0] last_row_of(logic [pxu_pkg::HEIGHT_REG_W-1:0] h);
      int v;
      v = int'(h);
      if (v == 0) v = 1;
      if (v > MAX_HEIGHT) v = MAX_HEIGHT;
      return RW'(v - 1);
   endfunction

   // ---------------------------------------------------------------------------
   // Size registers and raster position
   // ---------------------------------------------------------------------------
   logic [CW-1:0]       last_col_ff;
   logic [RW-1:0]       last_row_ff;
   logic [CW-1:0]       col_ff;
   logic [RW-1:0]       row_ff;
   pxu_pkg::pixel_type  left_ff;
   pxu_pkg::pixel_type  above_left_ff;

   logic                req_ready;
   logic                req_take;
   pxu_pkg::pixel_type  req_px;
   logic                at_first_col;
   logic                at_last_col;
   logic                at_last_row;

   assign req_px.c0    = req_chan.chan_0;
   assign req_px.c1    = req_chan.chan_1;
   assign req_px.c2    = req_chan.chan_2;
   assign req_take     = req_chan.valid && req_ready;
   assign at_first_col = (col_ff == '0);
   assign at_last_col  = (col_ff == last_col_ff);
   assign at_last_row  = (row_ff == last_row_ff);

   // Stage A: the accepted pixel waits here while the line buffer read completes.
   logic                a_valid_ff;
   pxu_pkg::pixel_type  a_px_ff;
   logic [CW-1:0]       a_col_ff;
   logic [RW-1:0]       a_row_ff;
   logic                a_first_col_ff;
   logic                a_last_col_ff;
   logic                a_last_row_ff;

   // Stage B emits a 3x3 mask of output positions, one beat a cycle unless stalled.
   // Mask row 0/1/2 = output rows 2r-1, 2r, 2r+1; column 0/1/2 = 2c-1, 2c, 2c+1.
   logic                b_valid_ff;
   pxu_pkg::pixel_type  b_px_ff;
   pxu_pkg::pixel_type  b_above_ff;
   pxu_pkg::pixel_type  b_left_ff;
   pxu_pkg::pixel_type  b_above_left_ff;
   logic [CW-1:0]       b_col_ff;
   logic [RW-1:0]       b_row_ff;
   logic                b_frame_end_ff;
   logic [2:0][2:0]     b_mask_ff;
   logic [2:0][2:0]     b_mask_in;

   // Result register
   logic                          rsp_valid_ff;
   logic [pxu_pkg::OUT_X_W-1:0]   rsp_x_ff;
   logic [pxu_pkg::OUT_Y_W-1:0]   rsp_y_ff;
   pxu_pkg::pixel_type            rsp_px_ff;
   logic                          rsp_last_ff;
   logic                          rsp_frame_ff;

   logic                a_to_b;
   logic                out_load;
   logic                b_last_beat;
   logic                b_done;
   pxu_pkg::pixel_type  ram_rd_data;
   pxu_pkg::pixel_type  above_px;

   assign out_load    = b_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign b_done      = out_load && b_last_beat;
   assign a_to_b      = a_valid_ff && (!b_valid_ff || b_done);
   assign req_ready   = !a_valid_ff || a_to_b;
   assign req_chan.ready = req_ready;

   // Top input row has nothing above it.
   assign above_px = (a_row_ff == '0) ? '0 : ram_rd_data;

   // Line buffer: read the entry of the row above and overwrite it in the same edge.
   pxu_ram #(
      .WIDTH ($bits(pxu_pkg::pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (col_ff),
      .wr_data (req_px),
      .rd_en   (req_take),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // Sizes, raster position and the left / above-left history.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff   <= last_col_of(pxu_pkg::WIDTH_REG_W'(pxu_pkg::RESET_WIDTH));
         last_row_ff   <= last_row_of(pxu_pkg::HEIGHT_REG_W'(pxu_pkg::RESET_HEIGHT));
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
      end else if (csr_wr_en) begin
         // Any write restarts the frame.
         case (csr_index)
            pxu_pkg::CSR_IMAGE_WIDTH: begin
               last_col_ff <= last_col_of(csr_wr_data[pxu_pkg::WIDTH_REG_W-1:0]);
            end
            pxu_pkg::CSR_IMAGE_HEIGHT: begin
               last_row_ff <= last_row_of(csr_wr_data[pxu_pkg::HEIGHT_REG_W-1:0]);
            end
            default: begin
            end
         endcase
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
      end else begin
         if (req_take) begin
            if (at_last_col) begin
               col_ff <= '0;
               row_ff <= at_last_row ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (a_to_b) begin
            left_ff       <= a_px_ff;
            above_left_ff <= above_px;
         end
      end
   end

   // Stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_take) begin
         a_valid_ff <= 1'b1;
      end else if (a_to_b) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_px_ff        <= req_px;
         a_col_ff       <= col_ff;
         a_row_ff       <= row_ff;
         a_first_col_ff <= at_first_col;
         a_last_col_ff  <= at_last_col;
         a_last_row_ff  <= at_last_row;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage B: pick the lowest pending position, drop it from the mask.
   // ---------------------------------------------------------------------------
   logic [1:0]          sel_row;
   logic [1:0]          sel_col;
   logic [2:0][2:0]     sel_hot;
   logic [2:0][2:0]     b_rem;
   logic [2:0]          row_en;
   logic [2:0]          col_en;
   logic [2:0][2:0]     a_mask;

   always_comb begin
      sel_row = 2'd0;
      sel_col = 2'd0;
      for (int r = 2; r >= 0; r--) begin
         for (int c = 2; c >= 0; c--) begin
            if (b_mask_ff[r][c]) begin
               sel_row = 2'(r);
               sel_col = 2'(c);
            end
         end
      end
      sel_hot = '0;
      sel_hot[sel_row][sel_col] = 1'b1;
      b_rem = b_mask_ff & ~sel_hot;
   end

   assign b_last_beat = (b_rem == '0);

   // Positions that this pixel completes.
   assign row_en = {a_last_row_ff, 1'b1, (a_row_ff != '0)};
   assign col_en = {a_last_col_ff, 1'b1, !a_first_col_ff};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            a_mask[r][c] = row_en[r] && col_en[c];
         end
      end
   end

   always_comb begin
      b_mask_in = b_mask_ff;
      if (a_to_b) begin
         b_mask_in = a_mask;
      end else if (out_load) begin
         b_mask_in = b_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_mask_ff  <= '0;
      end else begin
         b_mask_ff <= b_mask_in;
         if (a_to_b) begin
            b_valid_ff <= 1'b1;
         end else if (b_done) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_to_b) begin
         b_px_ff         <= a_px_ff;
         b_above_ff      <= above_px;
         b_left_ff       <= left_ff;
         b_above_left_ff <= above_left_ff;
         b_col_ff        <= a_col_ff;
         b_row_ff        <= a_row_ff;
         b_frame_end_ff  <= a_last_row_ff && a_last_col_ff;
      end
   end

   // Pixel values of the selected position.
   pxu_pkg::pixel_type left_mid;
   pxu_pkg::pixel_type above_mid;
   pxu_pkg::pixel_type vert_mid;
   pxu_pkg::pixel_type center_mid;
   pxu_pkg::pixel_type sel_px;
   logic [31:0]        x_full;
   logic [31:0]        y_full;

   assign left_mid   = pxu_pkg::mean_px(b_left_ff, b_px_ff);
   assign above_mid  = pxu_pkg::mean_px(b_above_left_ff, b_above_ff);
   assign vert_mid   = pxu_pkg::mean_px(b_above_ff, b_px_ff);
   assign center_mid = pxu_pkg::mean_px(above_mid, left_mid);

   always_comb begin
      if (sel_row == 2'd0) begin
         sel_px = (sel_col == 2'd0) ? center_mid : vert_mid;
      end else begin
         sel_px = (sel_col == 2'd0) ? left_mid : b_px_ff;
      end
   end

   // Output coordinate = 2 * input + offset - 1, kept to the field width.
   assign x_full = (32'(b_col_ff) << 1) + 32'(sel_col) - 32'd1;
   assign y_full = (32'(b_row_ff) << 1) + 32'(sel_row) - 32'd1;

   // ---------------------------------------------------------------------------
   // Result register: load a beat when empty or when the current one is taken.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_x_ff     <= x_full[pxu_pkg::OUT_X_W-1:0];
         rsp_y_ff     <= y_full[pxu_pkg::OUT_Y_W-1:0];
         rsp_px_ff    <= sel_px;
         rsp_last_ff  <= b_last_beat;
         rsp_frame_ff <= b_last_beat && b_frame_end_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_x        = rsp_x_ff;
   assign rsp_chan.out_y        = rsp_y_ff;
   assign rsp_chan.res_0        = rsp_px_ff.c0;
   assign rsp_chan.res_1        = rsp_px_ff.c1;
   assign rsp_chan.res_2        = rsp_px_ff.c2;
   assign rsp_chan.last_of_item = rsp_last_ff;
   assign rsp_chan.frame_done   = rsp_frame_ff;

endmodule

### hw/rtl/pxu_checker.sv
// ----------------------------------------------------------------------------
// pxu_checker
// Port-level checks on the result channel of the 2x pixel upscaler.
// ----------------------------------------------------------------------------
`include "pixel_upscale_2x_average_core_assert.svh"

module pxu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pxu_pkg::OUT_X_W-1:0]   out_x,
   input logic [pxu_pkg::OUT_Y_W-1:0]   out_y,
   input logic                          last_of_item,
   input logic                          frame_done
);

   // A stalled beat stays and holds its position.
   `PXU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y), "rsp beat dropped or changed while stalled")

   // The frame's final beat closes its input pixel's group.
   `PXU_ASSERT(a_frame_closes_item, rsp_valid && frame_done |-> last_of_item, "frame_done without last_of_item")

   // The frame's final beat sits on the last, odd, output row and column.
   `PXU_ASSERT(a_frame_corner, rsp_valid && frame_done |-> out_x[0] && out_y[0], "frame_done off the bottom-right corner")

   // Reset empties the result register.
   `PXU_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind pixel_upscale_2x_average_core pxu_checker u_pxu_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .out_x        (rsp_chan.out_x),
   .out_y        (rsp_chan.out_y),
   .last_of_item (rsp_chan.last_of_item),
   .frame_done   (rsp_chan.frame_done)
);
